>>> rtl/abrv_pkg.sv
// shared types, constants and the crc step of the bank record validator
`default_nettype none
package abrv_pkg;

	localparam int unsigned BANK_BYTES = 12288;
	localparam int unsigned POS_W = 17;
	localparam int unsigned BODY_W = 18;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW = $clog2(Q_DEPTH);

	localparam logic [31:0] CRC_POLY = 32'hedb88320;
	localparam logic [31:0] ALL_ONES = 32'hffffffff;
	localparam logic [31:0] REC_MAGIC = 32'h53565244;
	localparam logic [15:0] REC_VERSION = 16'd1;
	localparam logic [POS_W-1:0] HDR_LEN = POS_W'(16);

	localparam logic [POS_W-1:0] POS_MAGIC = POS_W'(3);
	localparam logic [POS_W-1:0] POS_VERSION = POS_W'(5);
	localparam logic [POS_W-1:0] POS_WIRE = POS_W'(7);
	localparam logic [POS_W-1:0] POS_SEQ = POS_W'(11);
	localparam logic [POS_W-1:0] POS_RLEN = POS_W'(13);
	localparam logic [POS_W-1:0] POS_WLEN = POS_W'(15);

	localparam logic [BODY_W-1:0] BODY_MAX = BODY_W'(BANK_BYTES - 4);

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_MAGIC = 3'd1;
	localparam logic [2:0] ST_VERSION = 3'd2;
	localparam logic [2:0] ST_WIRE = 3'd3;
	localparam logic [2:0] ST_LENGTH = 3'd4;
	localparam logic [2:0] ST_OVERFLOW = 3'd5;
	localparam logic [2:0] ST_CRC = 3'd6;

	localparam logic [1:0] REG_WIRE_SIZE = 2'd0;
	localparam logic [1:0] REG_READINGS_LIMIT = 2'd1;
	localparam logic [1:0] REG_WEATHER_LIMIT = 2'd2;

	localparam logic [15:0] RST_WIRE_SIZE = 16'd16;
	localparam logic [15:0] RST_READINGS_LIMIT = 16'd8192;
	localparam logic [15:0] RST_WEATHER_LIMIT = 16'd512;

	typedef enum logic [1:0] {
		OP_BYTE,
		OP_START,
		OP_START_LOAD
	} op_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_bank;
		logic       bank_index;
		logic       new_load;
	} in_word_t;

	typedef struct packed {
		logic        record_valid;
		logic [2:0]  status;
		logic [31:0] seq_number;
		logic [15:0] readings_len;
		logic [15:0] weather_len;
		logic [16:0] weather_offset;
		logic        any_found;
		logic        selected_bank;
		logic [31:0] selected_seq;
	} out_word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       bank_index;
		op_t        op;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_head_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/abrv_front.sv
// input stage: takes bytes and classifies them into queue entries
`default_nettype none
module abrv_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire abrv_pkg::in_word_t item,
	output logic                   push,
	output abrv_pkg::q_entry_t     push_entry,
	input  wire logic              q_full
);

	logic               valid_s1;
	abrv_pkg::q_entry_t entry_s1;
	logic               take;

	assign push = valid_s1 && !q_full;
	assign item_ready = !valid_s1 || push;
	assign take = item_valid && item_ready;
	assign push_entry = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_s1.data_byte <= item.data_byte;
			entry_s1.bank_index <= item.bank_index;
			if (!item.first_of_bank) begin
				entry_s1.op <= abrv_pkg::OP_BYTE;
			end else if (item.new_load) begin
				entry_s1.op <= abrv_pkg::OP_START_LOAD;
			end else begin
				entry_s1.op <= abrv_pkg::OP_START;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/abrv_queue.sv
// short queue between the input stage and the record checker
`default_nettype none
module abrv_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire abrv_pkg::q_entry_t  push_entry,
	output logic                    full,
	output abrv_pkg::q_head_t       head,
	input  wire logic               pop
);

	abrv_pkg::q_entry_t            mem_q [abrv_pkg::Q_DEPTH];
	logic [abrv_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [abrv_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [abrv_pkg::Q_AW:0]       count_q;

	assign full = (count_q == (abrv_pkg::Q_AW+1)'(abrv_pkg::Q_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/abrv_back.sv
// record checker: header parse, crc, bank selection and result register
`default_nettype none
module abrv_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire abrv_pkg::q_head_t  head,
	output logic                    pop,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output abrv_pkg::out_word_t     result
);

	localparam int unsigned PW = abrv_pkg::POS_W;
	localparam int unsigned BW = abrv_pkg::BODY_W;

	logic [15:0]   wire_size_q, rd_limit_q, wx_limit_q;
	logic [PW-1:0] pos_q, body_q, body_end_q;
	logic [31:0]   crc_q, wa_q, seq_q, best_seq_q;
	logic [15:0]   rlen_q, wlen_q;
	logic          fin_q, cur_bank_q, best_found_q, best_bank_q;
	logic          out_valid_q;
	abrv_pkg::out_word_t out_q;

	logic          first, newload;
	logic [7:0]    b;
	logic [PW-1:0] pos_e, pos_n;
	logic [31:0]   crc_e, crc_n, wa_e, wa_n, seq_e, seq_n, bseq_e, bseq_n;
	logic [15:0]   rlen_e, rlen_n, wlen_e, wlen_n;
	logic          fin_e, fin_n, bank_e, bf_e, bf_n, bb_e, bb_n;
	logic [BW-1:0] body_full;
	logic          load_body;
	logic          emit, ok;
	logic [2:0]    code;

	assign pop = head.valid && (!out_valid_q || result_ready);
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		b = head.entry.data_byte;
		first = (head.entry.op != abrv_pkg::OP_BYTE);
		newload = (head.entry.op == abrv_pkg::OP_START_LOAD);

		fin_e = first ? 1'b0 : fin_q;
		pos_e = first ? '0 : pos_q;
		crc_e = first ? abrv_pkg::ALL_ONES : crc_q;
		wa_e = first ? 32'd0 : wa_q;
		seq_e = first ? 32'd0 : seq_q;
		rlen_e = first ? 16'd0 : rlen_q;
		wlen_e = first ? 16'd0 : wlen_q;
		bank_e = first ? head.entry.bank_index : cur_bank_q;
		bf_e = newload ? 1'b0 : best_found_q;
		bb_e = newload ? 1'b1 : best_bank_q;
		bseq_e = newload ? 32'd0 : best_seq_q;

		fin_n = fin_e;
		pos_n = pos_e;
		crc_n = crc_e;
		wa_n = wa_e;
		seq_n = seq_e;
		rlen_n = rlen_e;
		wlen_n = wlen_e;
		bf_n = bf_e;
		bb_n = bb_e;
		bseq_n = bseq_e;
		emit = 1'b0;
		code = abrv_pkg::ST_OK;
		load_body = 1'b0;
		body_full = BW'(abrv_pkg::HDR_LEN) + BW'(rlen_e) + BW'({b, wa_e[31:24]});

		if (!fin_e) begin
			pos_n = pos_e + 1'b1;
			wa_n = {b, wa_e[31:8]};
			if (pos_e < abrv_pkg::HDR_LEN) begin
				crc_n = abrv_pkg::crc_byte(crc_e, b);
				if (pos_e == abrv_pkg::POS_MAGIC && wa_n != abrv_pkg::REC_MAGIC) begin
					emit = 1'b1;
					code = abrv_pkg::ST_MAGIC;
				end
				if (pos_e == abrv_pkg::POS_VERSION && wa_n[31:16] != abrv_pkg::REC_VERSION) begin
					emit = 1'b1;
					code = abrv_pkg::ST_VERSION;
				end
				if (pos_e == abrv_pkg::POS_WIRE && wa_n[31:16] != wire_size_q) begin
					emit = 1'b1;
					code = abrv_pkg::ST_WIRE;
				end
				if (pos_e == abrv_pkg::POS_SEQ) begin
					seq_n = wa_n;
				end
				if (pos_e == abrv_pkg::POS_RLEN) begin
					rlen_n = wa_n[31:16];
				end
				if (pos_e == abrv_pkg::POS_WLEN) begin
					wlen_n = wa_n[31:16];
					load_body = 1'b1;
					if (rlen_e > rd_limit_q || wa_n[31:16] > wx_limit_q) begin
						emit = 1'b1;
						code = abrv_pkg::ST_LENGTH;
					end else if (body_full > abrv_pkg::BODY_MAX) begin
						emit = 1'b1;
						code = abrv_pkg::ST_OVERFLOW;
					end
				end
			end else if (pos_e < body_q) begin
				crc_n = abrv_pkg::crc_byte(crc_e, b);
			end else if (pos_e == body_end_q) begin
				emit = 1'b1;
				code = ((crc_e ^ wa_n) == abrv_pkg::ALL_ONES) ? abrv_pkg::ST_OK
					: abrv_pkg::ST_CRC;
			end
		end

		ok = (code == abrv_pkg::ST_OK);
		if (emit) begin
			fin_n = 1'b1;
			if (ok && (!bf_e || seq_e > bseq_e)) begin
				bf_n = 1'b1;
				bb_n = bank_e;
				bseq_n = seq_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wire_size_q <= abrv_pkg::RST_WIRE_SIZE;
			rd_limit_q <= abrv_pkg::RST_READINGS_LIMIT;
			wx_limit_q <= abrv_pkg::RST_WEATHER_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				abrv_pkg::REG_WIRE_SIZE: wire_size_q <= cfg_data;
				abrv_pkg::REG_READINGS_LIMIT: rd_limit_q <= cfg_data;
				abrv_pkg::REG_WEATHER_LIMIT: wx_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= abrv_pkg::ALL_ONES;
			wa_q <= '0;
			seq_q <= '0;
			rlen_q <= '0;
			wlen_q <= '0;
			fin_q <= 1'b1;
			cur_bank_q <= 1'b0;
			best_found_q <= 1'b0;
			best_bank_q <= 1'b1;
			best_seq_q <= '0;
			body_q <= '0;
			body_end_q <= '0;
		end else if (pop) begin
			pos_q <= pos_n;
			crc_q <= crc_n;
			wa_q <= wa_n;
			seq_q <= seq_n;
			rlen_q <= rlen_n;
			wlen_q <= wlen_n;
			fin_q <= fin_n;
			cur_bank_q <= bank_e;
			best_found_q <= bf_n;
			best_bank_q <= bb_n;
			best_seq_q <= bseq_n;
			if (load_body) begin
				body_q <= body_full[PW-1:0];
				body_end_q <= PW'(body_full + BW'(3));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_q.record_valid <= ok;
			out_q.status <= code;
			out_q.seq_number <= ok ? seq_e : 32'd0;
			out_q.readings_len <= ok ? rlen_e : 16'd0;
			out_q.weather_len <= ok ? wlen_e : 16'd0;
			out_q.weather_offset <= ok ? (17'(abrv_pkg::HDR_LEN) + 17'(rlen_e)) : 17'd0;
			out_q.any_found <= bf_n;
			out_q.selected_bank <= bb_n;
			out_q.selected_seq <= bseq_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/ab_bank_record_validator.sv
// an accepted byte is registered in the input stage, then written into the queue, before the checker reads it
// a result is registered at the edge the record's last checked byte is processed
// throughput is one byte per cycle, set by the one-byte crc step in the checker, while no result waits on result_ready
// reset clears the parser to idle (bytes ignored until a first byte), the queue and
// the bank selection, and loads the registers with 16, 8192 and 512
`default_nettype none
module ab_bank_record_validator (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire logic                item_valid,
	output logic                     item_ready,
	input  wire abrv_pkg::in_word_t  item,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output abrv_pkg::out_word_t      result
);

	logic               push, q_full, pop;
	abrv_pkg::q_entry_t push_entry;
	abrv_pkg::q_head_t  head;

	abrv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	abrv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.head       (head),
		.pop        (pop)
	);

	abrv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

>>> sim/ab_bank_record_validator_tb.sv
// self-checking testbench for the bank record validator: framed records, faults and noise
`default_nettype none
module ab_bank_record_validator_tb;
	import abrv_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned DRAIN_CYCLES = 20;

	typedef enum int {
		FLT_NONE,
		FLT_MAGIC,
		FLT_VERSION,
		FLT_CRC,
		FLT_CUT,
		FLT_HEADER
	} fault_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_WIRE_SIZE;
	logic [15:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	in_word_t    item_word = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	out_word_t   result_word;

	in_word_t    bytes_to_send[$];
	out_word_t   pending_results[$];
	int unsigned words_queued = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	bit          steady = 1'b0;

	// parser copy
	logic [15:0] cfg_wire, cfg_rlim, cfg_wlim;
	logic [16:0] pos_cnt;
	logic [31:0] crc_run, shift_word, hdr_seq;
	logic [15:0] hdr_rlen, hdr_wlen;
	bit          idle_parse, cur_bank, have_best, best_bank_q;
	logic [31:0] best_seq_q;

	ab_bank_record_validator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		bit fb;
		r = c;
		for (int k = 0; k < 8; k++) begin
			fb = r[0] ^ d[k];
			r = (r >> 1) ^ (fb ? CRC_POLY : 32'd0);
		end
		return r;
	endfunction

	function automatic out_word_t close_record(input logic [2:0] code);
		out_word_t r;
		bit ok;
		ok = (code == ST_OK);
		idle_parse = 1'b1;
		if (ok && (!have_best || hdr_seq > best_seq_q)) begin
			have_best = 1'b1;
			best_bank_q = cur_bank;
			best_seq_q = hdr_seq;
		end
		r.record_valid = ok;
		r.status = code;
		r.seq_number = ok ? hdr_seq : 32'd0;
		r.readings_len = ok ? hdr_rlen : 16'd0;
		r.weather_len = ok ? hdr_wlen : 16'd0;
		r.weather_offset = ok ? 17'(HDR_LEN + hdr_rlen) : 17'd0;
		r.any_found = have_best;
		r.selected_bank = best_bank_q;
		r.selected_seq = best_seq_q;
		return r;
	endfunction

	function automatic bit parse_byte(input in_word_t w, output out_word_t r);
		logic [16:0] p;
		int unsigned body;
		bit fire;
		logic [2:0] code;
		fire = 1'b0;
		code = ST_OK;
		r = '0;
		if (w.first_of_bank) begin
			pos_cnt = '0;
			crc_run = ALL_ONES;
			shift_word = '0;
			hdr_seq = '0;
			hdr_rlen = '0;
			hdr_wlen = '0;
			idle_parse = 1'b0;
			cur_bank = w.bank_index;
			if (w.new_load) begin
				have_best = 1'b0;
				best_bank_q = 1'b1;
				best_seq_q = '0;
			end
		end
		if (idle_parse)
			return 1'b0;
		p = pos_cnt;
		pos_cnt = pos_cnt + 17'd1;
		shift_word = {w.data_byte, shift_word[31:8]};
		body = int'(HDR_LEN) + int'(hdr_rlen) + int'(hdr_wlen);
		if (p < HDR_LEN) begin
			crc_run = crc_update(crc_run, w.data_byte);
			if (p == POS_MAGIC && shift_word != REC_MAGIC) begin
				fire = 1'b1;
				code = ST_MAGIC;
			end else if (p == POS_VERSION && shift_word[31:16] != REC_VERSION) begin
				fire = 1'b1;
				code = ST_VERSION;
			end else if (p == POS_WIRE && shift_word[31:16] != cfg_wire) begin
				fire = 1'b1;
				code = ST_WIRE;
			end else if (p == POS_SEQ) begin
				hdr_seq = shift_word;
			end else if (p == POS_RLEN) begin
				hdr_rlen = shift_word[31:16];
			end else if (p == POS_WLEN) begin
				hdr_wlen = shift_word[31:16];
				body = int'(HDR_LEN) + int'(hdr_rlen) + int'(hdr_wlen);
				if (hdr_rlen > cfg_rlim || hdr_wlen > cfg_wlim) begin
					fire = 1'b1;
					code = ST_LENGTH;
				end else if (body + 4 > BANK_BYTES) begin
					fire = 1'b1;
					code = ST_OVERFLOW;
				end
			end
		end else if (p < body) begin
			crc_run = crc_update(crc_run, w.data_byte);
		end else if (p == body + 3) begin
			fire = 1'b1;
			code = ((crc_run ^ shift_word) == ALL_ONES) ? ST_OK : ST_CRC;
		end
		if (fire)
			r = close_record(code);
		return fire;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s got %0h want %0h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic push_word(input logic [7:0] d, input bit first, input bit bank, input bit load);
		in_word_t w;
		w.data_byte = d;
		w.first_of_bank = first;
		w.bank_index = bank;
		w.new_load = load;
		bytes_to_send.push_back(w);
		words_queued++;
	endtask

	task automatic push_noise(input int unsigned n, input bit allow_first);
		for (int i = 0; i < n; i++) begin
			push_word(8'($urandom), allow_first && ($urandom_range(0, 9) == 0),
				1'($urandom), 1'($urandom));
		end
	endtask

	task automatic push_record(input bit bank, input bit load, input logic [31:0] seq,
			input logic [15:0] wire_sz, input logic [15:0] rlen, input logic [15:0] wlen,
			input fault_t flt);
		logic [7:0] img[$];
		logic [127:0] hdr;
		logic [31:0] c;
		int unsigned cut;
		hdr = {wlen, rlen, seq, wire_sz, REC_VERSION, REC_MAGIC};
		for (int k = 0; k < 16; k++)
			img.push_back(hdr[8*k +: 8]);
		if (flt == FLT_MAGIC)
			img[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
		if (flt == FLT_VERSION)
			img[4 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
		if (flt != FLT_HEADER && rlen <= cfg_rlim && wlen <= cfg_wlim
				&& int'(rlen) + int'(wlen) + 20 <= BANK_BYTES) begin
			for (int k = 0; k < int'(rlen) + int'(wlen); k++)
				img.push_back(8'($urandom));
		end
		c = ALL_ONES;
		foreach (img[k])
			c = crc_update(c, img[k]);
		c = ~c;
		for (int k = 0; k < 4; k++)
			img.push_back(c[8*k +: 8]);
		if (flt == FLT_CRC)
			img[$urandom_range(16, img.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
		if (flt == FLT_CUT) begin
			cut = $urandom_range(1, img.size() - 1);
			img = img[0:cut-1];
		end
		// header only, the next first byte drops the record
		if (flt == FLT_HEADER)
			img = img[0:15];
		foreach (img[k]) begin
			if (k == 0)
				push_word(img[k], 1'b1, bank, load);
			else
				push_word(img[k], 1'b0, 1'($urandom), 1'($urandom));
		end
	endtask

	task automatic random_records(input int unsigned n);
		int unsigned start, pick, rmax, wmax;
		logic [31:0] seq;
		logic [15:0] wire_sz, rlen, wlen;
		fault_t flt;
		start = words_queued;
		while (words_queued - start < n) begin
			pick = $urandom_range(0, 99);
			rmax = (cfg_rlim < 24) ? cfg_rlim : 24;
			wmax = (cfg_wlim < 24) ? cfg_wlim : 24;
			rlen = 16'($urandom_range(0, rmax));
			wlen = 16'($urandom_range(0, wmax));
			wire_sz = cfg_wire;
			seq = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom);
			flt = FLT_NONE;
			if (pick < 92) begin
				if (pick >= 60 && pick < 65)
					flt = FLT_MAGIC;
				else if (pick >= 65 && pick < 70)
					flt = FLT_VERSION;
				else if (pick >= 70 && pick < 75)
					wire_sz = cfg_wire ^ 16'($urandom_range(1, 65535));
				else if (pick >= 75 && pick < 82)
					flt = FLT_CRC;
				else if (pick >= 82 && pick < 87)
					flt = FLT_CUT;
				else if (pick >= 87) begin
					if (cfg_rlim != 16'hffff && $urandom_range(0, 1) == 0)
						rlen = cfg_rlim + 16'd1;
					else if (cfg_wlim != 16'hffff)
						wlen = cfg_wlim + 16'd1;
					else
						rlen = 16'(BANK_BYTES - 19);
				end
				push_record(1'($urandom), $urandom_range(0, 99) < 15, seq, wire_sz, rlen, wlen,
					flt);
				if ($urandom_range(0, 9) < 3)
					push_noise($urandom_range(1, 3), 1'b0);
			end else begin
				push_noise($urandom_range(1, 6), 1'b1);
			end
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_WIRE_SIZE: cfg_wire = value;
			REG_READINGS_LIMIT: cfg_rlim = value;
			REG_WEATHER_LIMIT: cfg_wlim = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(input logic [15:0] wire_sz, input logic [15:0] rl,
			input logic [15:0] wl);
		write_reg(REG_WIRE_SIZE, wire_sz);
		write_reg(REG_READINGS_LIMIT, rl);
		write_reg(REG_WEATHER_LIMIT, wl);
	endtask

	task automatic drain_and_pause();
		while (bytes_to_send.size() != 0 || item_valid || pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// driver: predicts each accepted word, then offers the next one
	always @(posedge clk) begin
		out_word_t r;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				if (parse_byte(item_word, r))
					pending_results.push_back(r);
			end
			if (!item_valid || item_ready) begin
				if (bytes_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
					item_word <= bytes_to_send.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_word_t e;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected word", 64'(result_word.status), 64'd0);
				end else begin
					e = pending_results.pop_front();
					if (result_word.record_valid !== e.record_valid)
						report_mismatch("record_valid", 64'(result_word.record_valid),
							64'(e.record_valid));
					if (result_word.status !== e.status)
						report_mismatch("status", 64'(result_word.status), 64'(e.status));
					if (result_word.seq_number !== e.seq_number)
						report_mismatch("seq_number", 64'(result_word.seq_number),
							64'(e.seq_number));
					if (result_word.readings_len !== e.readings_len)
						report_mismatch("readings_len", 64'(result_word.readings_len),
							64'(e.readings_len));
					if (result_word.weather_len !== e.weather_len)
						report_mismatch("weather_len", 64'(result_word.weather_len),
							64'(e.weather_len));
					if (result_word.weather_offset !== e.weather_offset)
						report_mismatch("weather_offset", 64'(result_word.weather_offset),
							64'(e.weather_offset));
					if (result_word.any_found !== e.any_found)
						report_mismatch("any_found", 64'(result_word.any_found),
							64'(e.any_found));
					if (result_word.selected_bank !== e.selected_bank)
						report_mismatch("selected_bank", 64'(result_word.selected_bank),
							64'(e.selected_bank));
					if (result_word.selected_seq !== e.selected_seq)
						report_mismatch("selected_seq", 64'(result_word.selected_seq),
							64'(e.selected_seq));
				end
			end
			result_ready <= steady || ($urandom_range(0, 99) >= 25);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ab_bank_record_validator: mismatch");
			$finish;
		end
	end

	initial begin
		cfg_wire = RST_WIRE_SIZE;
		cfg_rlim = RST_READINGS_LIMIT;
		cfg_wlim = RST_WEATHER_LIMIT;
		pos_cnt = '0;
		crc_run = ALL_ONES;
		shift_word = '0;
		hdr_seq = '0;
		hdr_rlen = '0;
		hdr_wlen = '0;
		idle_parse = 1'b1;
		cur_bank = 1'b0;
		have_best = 1'b0;
		best_bank_q = 1'b1;
		best_seq_q = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset register values, directed records
		push_noise(3, 1'b0);
		push_record(1'b0, 1'b1, 32'd5, 16'd16, 16'd0, 16'd0, FLT_NONE);
		push_record(1'b1, 1'b0, 32'd5, 16'd16, 16'd2, 16'd1, FLT_NONE);
		push_record(1'b1, 1'b0, 32'd6, 16'd16, 16'd3, 16'd0, FLT_NONE);
		push_record(1'b0, 1'b0, 32'hffffffff, 16'd16, 16'd0, 16'd4, FLT_NONE);
		push_record(1'b0, 1'b0, 32'd7, 16'd16, 16'd1, 16'd1, FLT_MAGIC);
		push_record(1'b1, 1'b0, 32'd8, 16'd16, 16'd1, 16'd1, FLT_VERSION);
		push_record(1'b0, 1'b0, 32'd9, 16'd17, 16'd1, 16'd1, FLT_NONE);
		push_record(1'b1, 1'b0, 32'd10, 16'd16, 16'd2, 16'd2, FLT_CRC);
		push_record(1'b0, 1'b0, 32'd11, 16'd16, 16'd2, 16'd2, FLT_CUT);
		push_record(1'b1, 1'b1, 32'd0, 16'd16, 16'd0, 16'd0, FLT_NONE);
		push_record(1'b0, 1'b0, 32'd12, 16'd16, 16'd8193, 16'd0, FLT_NONE);
		push_record(1'b1, 1'b0, 32'd13, 16'd16, 16'd0, 16'd513, FLT_NONE);
		push_record(1'b0, 1'b0, 32'd14, 16'd16, 16'd1, 16'd0, FLT_NONE);
		push_noise(4, 1'b0);
		drain_and_pause();

		// widest limits: exact bank fit and overflow
		set_limits(16'd16, 16'hffff, 16'hffff);
		push_record(1'b1, 1'b1, 32'd20, 16'd16, 16'(BANK_BYTES - 20), 16'd0, FLT_HEADER);
		push_record(1'b0, 1'b0, 32'd21, 16'd16, 16'(BANK_BYTES - 19), 16'd0, FLT_NONE);
		push_record(1'b0, 1'b0, 32'd22, 16'd16, 16'd6000, 16'd6269, FLT_NONE);
		push_record(1'b1, 1'b0, 32'd23, 16'd16, 16'hffff, 16'hffff, FLT_NONE);
		random_records(220);
		drain_and_pause();

		set_limits(16'd0, 16'd0, 16'd0);
		random_records(180);
		drain_and_pause();

		set_limits(16'($urandom), 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
		steady = 1'b1;
		random_records(280);
		drain_and_pause();
		steady = 1'b0;

		set_limits(16'hffff, RST_READINGS_LIMIT, RST_WEATHER_LIMIT);
		random_records(220);
		drain_and_pause();

		set_limits(RST_WIRE_SIZE, 16'($urandom_range(8, 30)), 16'($urandom_range(0, 12)));
		random_records(200);
		drain_and_pause();

		if (mismatches == 0)
			$display("ab_bank_record_validator: match");
		else
			$display("ab_bank_record_validator: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
